// ===== src/pcx_rle_image_decoder_defines.svh =====
// assertion macros for the pcx rle image decoder
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef PCX_RLE_IMAGE_DECODER_DEFINES_SVH
`define PCX_RLE_IMAGE_DECODER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PCXD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcxd assertion failed");

// antecedent implies consequent in the next cycle
`define PCXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcxd assertion failed");

`endif

// ===== src/pcxd_pkg.sv =====
// shared types and constants of the pcx rle image decoder
// used by the controller, the datapath and the top level
package pcxd_pkg;

    localparam int unsigned HEADER_BYTES = 128;
    localparam logic [31:0] PAL_TAIL     = 32'd769;
    localparam logic [31:0] SHORT_ONE    = 32'd897;
    localparam logic [7:0]  MAKER_CODE   = 8'h0A;
    localparam logic [7:0]  PAL_MARK     = 8'h0C;

    // result kinds
    localparam logic [1:0] KIND_IMAGE   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_MAKER    = 4'd2;
    localparam logic [3:0] ST_ENCODING = 4'd3;
    localparam logic [3:0] ST_FORMAT   = 4'd4;
    localparam logic [3:0] ST_GEOMETRY = 4'd5;
    localparam logic [3:0] ST_SIZE     = 4'd6;
    localparam logic [3:0] ST_PALETTE  = 4'd7;
    localparam logic [3:0] ST_RUN_CUT  = 4'd8;
    localparam logic [3:0] ST_COUNT    = 4'd9;
    localparam logic [3:0] ST_TRAILING = 4'd10;

    typedef enum logic [6:0] {
        S_IN   = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_CHK1 = 7'b0000100,
        S_CHK2 = 7'b0001000,
        S_CHK3 = 7'b0010000,
        S_RUN  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic eval;
        logic chk1;
        logic chk2;
        logic chk3;
        logic run_step;
        logic fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic ignore;
        logic hdr_done;
        logic run_start;
        logic run_done;
        logic final_byte;
    } stat_t;

endpackage

// ===== src/pcxd_ctrl.sv =====
// sequencing state machine of the pcx rle image decoder
// depends on pcxd_pkg for the state, command and status types
module pcxd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pcxd_pkg::stat_t  stat,
    output pcxd_pkg::cmd_t   cmd
);

    pcxd_pkg::state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            pcxd_pkg::S_IN: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = pcxd_pkg::S_EVAL;
                end
            end
            pcxd_pkg::S_EVAL: begin
                if (stat.out_free) begin
                    cmd.eval = 1'b1;
                    if (stat.ignore) begin
                        state_next = pcxd_pkg::S_IN;
                    end else if (stat.hdr_done) begin
                        state_next = pcxd_pkg::S_CHK1;
                    end else if (stat.run_start) begin
                        state_next = pcxd_pkg::S_RUN;
                    end else if (stat.final_byte) begin
                        state_next = pcxd_pkg::S_FIN;
                    end else begin
                        state_next = pcxd_pkg::S_IN;
                    end
                end
            end
            pcxd_pkg::S_CHK1: begin
                cmd.chk1   = 1'b1;
                state_next = pcxd_pkg::S_CHK2;
            end
            pcxd_pkg::S_CHK2: begin
                cmd.chk2   = 1'b1;
                state_next = pcxd_pkg::S_CHK3;
            end
            pcxd_pkg::S_CHK3: begin
                cmd.chk3   = 1'b1;
                state_next = stat.final_byte ? pcxd_pkg::S_FIN : pcxd_pkg::S_IN;
            end
            pcxd_pkg::S_RUN: begin
                if (stat.out_free) begin
                    cmd.run_step = 1'b1;
                    if (stat.run_done) begin
                        state_next = stat.final_byte ? pcxd_pkg::S_FIN : pcxd_pkg::S_IN;
                    end
                end
            end
            pcxd_pkg::S_FIN: begin
                if (stat.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = pcxd_pkg::S_IN;
                end
            end
            default: begin
                state_next = pcxd_pkg::S_IN;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcxd_pkg::S_IN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pcxd_datapath.sv =====
// header capture, header checks, rle expansion counters and result register
// depends on pcxd_pkg; driven by commands from pcxd_ctrl
module pcxd_datapath #(
    parameter int unsigned MAX_LINE_BYTES = 4096,
    parameter int unsigned MAX_PIXELS     = 67108864,
    parameter int unsigned CW             = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_file_length_we,
    input  logic [31:0]      cfg_file_length,
    input  logic [7:0]       s_byte_value,
    input  pcxd_pkg::cmd_t   cmd,
    output pcxd_pkg::stat_t  stat,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_value,
    output logic [15:0]      m_row,
    output logic [11:0]      m_column,
    output logic [1:0]       m_plane,
    output logic             m_keep,
    output logic             m_last,
    output logic [3:0]       m_status,
    output logic [12:0]      m_width,
    output logic [16:0]      m_height,
    output logic [1:0]       m_plane_count,
    output logic [12:0]      m_line_bytes
);

    // configuration and position
    logic [31:0] flen_reg, flen_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] p_reg, p_next;
    logic [7:0]  byte_reg, byte_next;
    logic        ign_reg, ign_next;
    logic        fin_reg, fin_next;

    // header fields
    logic [7:0]  maker_reg, maker_next;
    logic [7:0]  enc_reg, enc_next;
    logic [7:0]  bits_reg, bits_next;
    logic [15:0] xmin_reg, xmin_next;
    logic [15:0] ymin_reg, ymin_next;
    logic [15:0] xmax_reg, xmax_next;
    logic [15:0] ymax_reg, ymax_next;
    logic [7:0]  planes_reg, planes_next;
    logic [15:0] bpl_reg, bpl_next;

    // check products
    logic [33:0] wh_reg, wh_next;
    logic [32:0] bh_reg, bh_next;

    // decode state
    logic [31:0]   exp_reg, exp_next;
    logic [31:0]   dec_reg, dec_next;
    logic [15:0]   row_reg, row_next;
    logic [1:0]    plane_reg, plane_next;
    logic [CW-1:0] col_reg, col_next;
    logic          pend_reg, pend_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [5:0]    left_reg, left_next;
    logic [3:0]    err_reg, err_next;

    // result register
    logic        mv_reg, mv_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  val_reg, val_next;
    logic [15:0] orow_reg, orow_next;
    logic [11:0] ocol_reg, ocol_next;
    logic [1:0]  opl_reg, opl_next;
    logic        keep_reg, keep_next;
    logic        last_reg, last_next;
    logic [3:0]  ost_reg, ost_next;
    logic [12:0] ow_reg, ow_next;
    logic [16:0] oh_reg, oh_next;
    logic [1:0]  opc_reg, opc_next;
    logic [12:0] olb_reg, olb_next;

    // geometry
    logic [17:0] w18, h18, bpl18;
    logic        w_pos, h_pos, hdr_ok, in_hdr, out_free;
    logic [31:0] tail_start, room, exp3;
    logic [16:0] col17, col_inc;
    logic [7:0]  plane_inc;
    logic        img_keep;
    logic [5:0]  run_n;
    logic        run_cut;
    logic [3:0]  e1, e2, e3;
    logic        fin_ok;

    assign w18      = {2'b00, xmax_reg} - {2'b00, xmin_reg} + 18'd1;
    assign h18      = {2'b00, ymax_reg} - {2'b00, ymin_reg} + 18'd1;
    assign bpl18    = {2'b00, bpl_reg};
    assign w_pos    = !w18[17] && (w18 != 18'd0);
    assign h_pos    = !h18[17] && (h18 != 18'd0);
    assign hdr_ok   = (err_reg == pcxd_pkg::ST_OK) || (err_reg >= pcxd_pkg::ST_PALETTE);
    assign in_hdr   = (p_reg < 32'(pcxd_pkg::HEADER_BYTES));
    assign out_free = !mv_reg || m_ready;
    assign room     = exp_reg - dec_reg;
    assign exp3     = bh_reg[31:0] + {bh_reg[30:0], 1'b0};

    // end of image data, palette tail for one plane
    always_comb begin
        if (planes_reg == 8'd1) begin
            tail_start = (flen_reg >= pcxd_pkg::PAL_TAIL) ? flen_reg - pcxd_pkg::PAL_TAIL : 32'd0;
        end else begin
            tail_start = flen_reg;
        end
    end

    // position advance of one image byte
    assign col17     = {{(17-CW){1'b0}}, col_reg};
    assign col_inc   = col17 + 17'd1;
    assign plane_inc = {6'd0, plane_reg} + 8'd1;
    assign img_keep  = {1'b0, col17} < w18;

    // run length clipped to the bytes still expected
    assign run_cut = {26'd0, cnt_reg} > room;
    assign run_n   = run_cut ? room[5:0] : cnt_reg;

    // final error sequence
    always_comb begin
        e1 = err_reg;
        if (flen_reg < 32'(pcxd_pkg::HEADER_BYTES) && e1 == pcxd_pkg::ST_OK) begin
            e1 = pcxd_pkg::ST_SHORT;
        end
        fin_ok = (e1 == pcxd_pkg::ST_OK) || (e1 >= pcxd_pkg::ST_PALETTE);
        e2 = e1;
        if (fin_ok && pend_reg && e2 == pcxd_pkg::ST_OK) begin
            e2 = pcxd_pkg::ST_RUN_CUT;
        end
        e3 = e2;
        if (fin_ok && dec_reg != exp_reg && e3 == pcxd_pkg::ST_OK) begin
            e3 = pcxd_pkg::ST_COUNT;
        end
    end

    // status to the controller
    always_comb begin
        stat.out_free   = out_free;
        stat.ignore     = ign_reg;
        stat.hdr_done   = in_hdr && (p_reg[6:0] == 7'(pcxd_pkg::HEADER_BYTES - 1));
        stat.run_start  = !in_hdr && hdr_ok && (p_reg < tail_start) && pend_reg
                          && (run_n != 6'd0);
        stat.run_done   = (left_reg == 6'd1);
        stat.final_byte = fin_reg;
    end

    // next values
    always_comb begin
        logic emit_img;
        logic emit_pal;
        emit_img    = 1'b0;
        emit_pal    = 1'b0;
        flen_next   = cfg_file_length_we ? cfg_file_length : flen_reg;
        pos_next    = pos_reg;
        p_next      = p_reg;
        byte_next   = byte_reg;
        ign_next    = ign_reg;
        fin_next    = fin_reg;
        maker_next  = maker_reg;
        enc_next    = enc_reg;
        bits_next   = bits_reg;
        xmin_next   = xmin_reg;
        ymin_next   = ymin_reg;
        xmax_next   = xmax_reg;
        ymax_next   = ymax_reg;
        planes_next = planes_reg;
        bpl_next    = bpl_reg;
        wh_next     = wh_reg;
        bh_next     = bh_reg;
        exp_next    = exp_reg;
        dec_next    = dec_reg;
        row_next    = row_reg;
        plane_next  = plane_reg;
        col_next    = col_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        err_next    = err_reg;
        mv_next     = m_ready ? 1'b0 : mv_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        opl_next    = opl_reg;
        keep_next   = keep_reg;
        last_next   = last_reg;
        ost_next    = ost_reg;
        ow_next     = ow_reg;
        oh_next     = oh_reg;
        opc_next    = opc_reg;
        olb_next    = olb_reg;

        // take the item and note its position
        if (cmd.accept) begin
            byte_next = s_byte_value;
            p_next    = pos_reg;
            ign_next  = (pos_reg >= flen_reg);
            fin_next  = (pos_reg < flen_reg) && (pos_reg == flen_reg - 32'd1);
            if (pos_reg < flen_reg) begin
                pos_next = pos_reg + 32'd1;
            end
        end

        // one byte of header or data
        if (cmd.eval && !ign_reg) begin
            if (in_hdr) begin
                case (p_reg[6:0])
                    7'd0:  maker_next       = byte_reg;
                    7'd2:  enc_next         = byte_reg;
                    7'd3:  bits_next        = byte_reg;
                    7'd4:  xmin_next[7:0]   = byte_reg;
                    7'd5:  xmin_next[15:8]  = byte_reg;
                    7'd6:  ymin_next[7:0]   = byte_reg;
                    7'd7:  ymin_next[15:8]  = byte_reg;
                    7'd8:  xmax_next[7:0]   = byte_reg;
                    7'd9:  xmax_next[15:8]  = byte_reg;
                    7'd10: ymax_next[7:0]   = byte_reg;
                    7'd11: ymax_next[15:8]  = byte_reg;
                    7'd65: planes_next      = byte_reg;
                    7'd66: bpl_next[7:0]    = byte_reg;
                    7'd67: bpl_next[15:8]   = byte_reg;
                    default: begin
                    end
                endcase
            end else if (hdr_ok) begin
                if (p_reg < tail_start) begin
                    if (pend_reg) begin
                        pend_next = 1'b0;
                        left_next = run_n;
                        if (run_cut && err_reg == pcxd_pkg::ST_OK) begin
                            err_next = pcxd_pkg::ST_RUN_CUT;
                        end
                    end else if (dec_reg >= exp_reg) begin
                        if (err_reg == pcxd_pkg::ST_OK) begin
                            err_next = pcxd_pkg::ST_TRAILING;
                        end
                    end else if (byte_reg[7:6] == 2'b11) begin
                        pend_next = 1'b1;
                        cnt_next  = byte_reg[5:0];
                    end else begin
                        emit_img = 1'b1;
                    end
                end else if (p_reg == tail_start) begin
                    pend_next = 1'b0;
                    if (pend_reg && err_reg == pcxd_pkg::ST_OK) begin
                        err_next = pcxd_pkg::ST_RUN_CUT;
                    end
                    if (byte_reg != pcxd_pkg::PAL_MARK) begin
                        err_next = pcxd_pkg::ST_PALETTE;
                    end
                end else if (err_reg != pcxd_pkg::ST_PALETTE) begin
                    emit_pal = 1'b1;
                end
            end
        end

        // expanded run bytes
        if (cmd.run_step) begin
            emit_img  = 1'b1;
            left_next = left_reg - 6'd1;
        end

        // image byte into the result register
        if (emit_img) begin
            mv_next   = 1'b1;
            kind_next = pcxd_pkg::KIND_IMAGE;
            val_next  = byte_reg;
            orow_next = row_reg;
            ocol_next = col17[11:0];
            opl_next  = plane_reg;
            keep_next = img_keep;
            last_next = !fin_reg && !(cmd.run_step && left_reg != 6'd1);
            ost_next  = pcxd_pkg::ST_OK;
            ow_next   = '0;
            oh_next   = '0;
            opc_next  = '0;
            olb_next  = '0;
            dec_next  = dec_reg + 32'd1;
            if (col_inc >= {1'b0, bpl_reg}) begin
                col_next = '0;
                if (plane_inc >= planes_reg) begin
                    plane_next = '0;
                    row_next   = row_reg + 16'd1;
                end else begin
                    plane_next = plane_inc[1:0];
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end

        // palette byte into the result register
        if (emit_pal) begin
            mv_next   = 1'b1;
            kind_next = pcxd_pkg::KIND_PALETTE;
            val_next  = byte_reg;
            orow_next = '0;
            ocol_next = 12'(p_reg - tail_start - 32'd1);
            opl_next  = '0;
            keep_next = 1'b0;
            last_next = !fin_reg;
            ost_next  = pcxd_pkg::ST_OK;
            ow_next   = '0;
            oh_next   = '0;
            opc_next  = '0;
            olb_next  = '0;
        end

        // header check over three steps
        if (cmd.chk1) begin
            wh_next = w18[16:0] * h18[16:0];
        end
        if (cmd.chk2) begin
            bh_next = bpl_reg * h18[16:0];
        end
        if (cmd.chk3) begin
            if (maker_reg != pcxd_pkg::MAKER_CODE) begin
                err_next = pcxd_pkg::ST_MAKER;
            end else if (enc_reg != 8'd1) begin
                err_next = pcxd_pkg::ST_ENCODING;
            end else if (bits_reg != 8'd8 || (planes_reg != 8'd1 && planes_reg != 8'd3)) begin
                err_next = pcxd_pkg::ST_FORMAT;
            end else if (!w_pos || !h_pos || bpl18 < w18
                         || 32'(bpl_reg) > 32'(MAX_LINE_BYTES)) begin
                err_next = pcxd_pkg::ST_GEOMETRY;
            end else if (wh_reg > 34'(MAX_PIXELS)) begin
                err_next = pcxd_pkg::ST_SIZE;
            end else if (planes_reg == 8'd1 && flen_reg < pcxd_pkg::SHORT_ONE) begin
                err_next = pcxd_pkg::ST_SHORT;
            end else begin
                exp_next = (planes_reg == 8'd3) ? exp3 : bh_reg[31:0];
            end
        end

        // final status
        if (cmd.fin) begin
            err_next  = e3;
            if (fin_ok) begin
                pend_next = 1'b0;
            end
            mv_next   = 1'b1;
            kind_next = pcxd_pkg::KIND_STATUS;
            val_next  = '0;
            orow_next = '0;
            ocol_next = '0;
            opl_next  = '0;
            keep_next = 1'b0;
            last_next = 1'b1;
            ost_next  = e3;
            if (e3 == pcxd_pkg::ST_OK) begin
                ow_next  = w18[12:0];
                oh_next  = h18[16:0];
                opc_next = planes_reg[1:0];
                olb_next = bpl_reg[12:0];
            end else begin
                ow_next  = '0;
                oh_next  = '0;
                opc_next = '0;
                olb_next = '0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flen_reg   <= '0;
            pos_reg    <= '0;
            ign_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            maker_reg  <= '0;
            enc_reg    <= '0;
            bits_reg   <= '0;
            xmin_reg   <= '0;
            ymin_reg   <= '0;
            xmax_reg   <= '0;
            ymax_reg   <= '0;
            planes_reg <= '0;
            bpl_reg    <= '0;
            exp_reg    <= '0;
            dec_reg    <= '0;
            row_reg    <= '0;
            plane_reg  <= '0;
            col_reg    <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            err_reg    <= pcxd_pkg::ST_OK;
            mv_reg     <= 1'b0;
        end else begin
            flen_reg   <= flen_next;
            pos_reg    <= pos_next;
            ign_reg    <= ign_next;
            fin_reg    <= fin_next;
            maker_reg  <= maker_next;
            enc_reg    <= enc_next;
            bits_reg   <= bits_next;
            xmin_reg   <= xmin_next;
            ymin_reg   <= ymin_next;
            xmax_reg   <= xmax_next;
            ymax_reg   <= ymax_next;
            planes_reg <= planes_next;
            bpl_reg    <= bpl_next;
            exp_reg    <= exp_next;
            dec_reg    <= dec_next;
            row_reg    <= row_next;
            plane_reg  <= plane_next;
            col_reg    <= col_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            err_reg    <= err_next;
            mv_reg     <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        byte_reg <= byte_next;
        wh_reg   <= wh_next;
        bh_reg   <= bh_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        opl_reg  <= opl_next;
        keep_reg <= keep_next;
        last_reg <= last_next;
        ost_reg  <= ost_next;
        ow_reg   <= ow_next;
        oh_reg   <= oh_next;
        opc_reg  <= opc_next;
        olb_reg  <= olb_next;
    end

    assign m_valid       = mv_reg;
    assign m_kind        = kind_reg;
    assign m_value       = val_reg;
    assign m_row         = orow_reg;
    assign m_column      = ocol_reg;
    assign m_plane       = opl_reg;
    assign m_keep        = keep_reg;
    assign m_last        = last_reg;
    assign m_status      = ost_reg;
    assign m_width       = ow_reg;
    assign m_height      = oh_reg;
    assign m_plane_count = opc_reg;
    assign m_line_bytes  = olb_reg;

endmodule

// ===== src/pcx_rle_image_decoder.sv =====
// PCX 8-bit RLE image decoder, one file byte per input item.
// Write cfg_file_length with the file size while idle, then stream the file
// on s_byte_value (valid/ready). Results leave on the m_ channel through one
// output register: image bytes tagged with row, plane, column and keep,
// palette bytes for one-plane files, and one final status item with the
// image size on the last file byte. m_last marks the last result of an item.
// Each input item is accepted, then evaluated; a run header byte produces
// nothing, its following byte then emits one result per cycle (up to 63)
// while input is held off and the receiver takes them. After the 128th
// header byte the header check forms its two products in turn and then
// tests the fields; the last file byte is followed by the status item.
// The evaluate, run and status steps wait while the output register holds
// an item that the receiver has not taken, so a stalled receiver stalls
// the input. A literal or palette byte enters the output register in its
// evaluate step, a run's bytes in the run state, and a status item in the
// final state, after the header check when the last byte ends the header.
// Reset (aresetn low, synchronous) clears the file length, the position and
// all decode state; a new file needs a reset before it starts.
// Bytes beyond the file length are taken and give no results.
module pcx_rle_image_decoder #(
    parameter int unsigned MAX_LINE_BYTES = 4096,
    parameter int unsigned MAX_PIXELS     = 67108864
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_file_length_we,
    input  logic [31:0] cfg_file_length,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_value,
    output logic [15:0] m_row,
    output logic [11:0] m_column,
    output logic [1:0]  m_plane,
    output logic        m_keep,
    output logic        m_last,
    output logic [3:0]  m_status,
    output logic [12:0] m_width,
    output logic [16:0] m_height,
    output logic [1:0]  m_plane_count,
    output logic [12:0] m_line_bytes
);

    `include "pcx_rle_image_decoder_defines.svh"

    localparam int unsigned CW = $clog2(MAX_LINE_BYTES);

    pcxd_pkg::cmd_t  cmd;
    pcxd_pkg::stat_t stat;

    // sequencer
    pcxd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // decode datapath
    pcxd_datapath #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_PIXELS     (MAX_PIXELS),
        .CW             (CW)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_file_length_we (cfg_file_length_we),
        .cfg_file_length    (cfg_file_length),
        .s_byte_value       (s_byte_value),
        .cmd                (cmd),
        .stat               (stat),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_value            (m_value),
        .m_row              (m_row),
        .m_column           (m_column),
        .m_plane            (m_plane),
        .m_keep             (m_keep),
        .m_last             (m_last),
        .m_status           (m_status),
        .m_width            (m_width),
        .m_height           (m_height),
        .m_plane_count      (m_plane_count),
        .m_line_bytes       (m_line_bytes)
    );

    // one item at a time: an accepted item is evaluated before the next
    `PCXD_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)
    // a status item always closes its input item
    `PCXD_ASSERT_NOW(a_status_last, m_valid && m_kind == pcxd_pkg::KIND_STATUS, m_last)
    // only a status item carries a status code
    `PCXD_ASSERT_NOW(a_status_zero, m_valid && m_kind != pcxd_pkg::KIND_STATUS,
                     m_status == pcxd_pkg::ST_OK)

endmodule
